/* src/mpd_pkg.sv */
// ----------------------------------------------------------------------------
// mpd_pkg: shared types and constants for the mouse packet event decoder
// Holds the sequencer states, event codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package mpd_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_HEIGHT = 1'd1;

    localparam logic [15:0] RST_DISPLAY_WIDTH  = 16'd800;
    localparam logic [15:0] RST_DISPLAY_HEIGHT = 16'd600;

    // Field widths
    localparam int POS_W    = 16;
    localparam int DELTA_W  = 9;
    localparam int NBUTTONS = 5;

    // Button indexes reported with wheel clicks
    localparam logic [2:0] BTN_WHEEL_DOWN = 3'd5;
    localparam logic [2:0] BTN_WHEEL_UP   = 3'd6;

    // Event codes
    typedef enum logic [2:0] {
        EV_MOVE       = 3'd0,
        EV_WHEEL_DOWN = 3'd1,
        EV_WHEEL_UP   = 3'd2,
        EV_PRESS      = 3'd3,
        EV_RELEASE    = 3'd4
    } t_event_kind;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC_X,
        S_CALC_Y,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

/* src/mpd_pkt_if.sv */
// ----------------------------------------------------------------------------
// mpd_pkt_if: input channel carrying one four-byte mouse packet
// Valid/ready handshake; a transaction moves one packet.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpd_pkt_if;
    logic       valid;
    logic       ready;
    logic [7:0] status_byte;
    logic [7:0] x_byte;
    logic [7:0] y_byte;
    logic [7:0] extra_byte;

    modport source (
        output valid, status_byte, x_byte, y_byte, extra_byte,
        input  ready
    );

    modport sink (
        input  valid, status_byte, x_byte, y_byte, extra_byte,
        output ready
    );
endinterface

`default_nettype wire

/* src/mpd_evt_if.sv */
// ----------------------------------------------------------------------------
// mpd_evt_if: output channel carrying one decoded mouse event
// Valid/ready handshake; a transaction moves one event.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpd_evt_if;
    logic              valid;
    logic              ready;
    logic [2:0]        event_kind;
    logic [2:0]        button_index;
    logic [15:0]       pointer_x;
    logic [15:0]       pointer_y;
    logic signed [9:0] scroll_dx;
    logic signed [8:0] scroll_dy;
    logic              last;

    modport source (
        output valid, event_kind, button_index, pointer_x, pointer_y,
               scroll_dx, scroll_dy, last,
        input  ready
    );

    modport sink (
        input  valid, event_kind, button_index, pointer_x, pointer_y,
               scroll_dx, scroll_dy, last,
        output ready
    );
endinterface

`default_nettype wire

/* src/mouse_packet_event_decoder.sv */
// ----------------------------------------------------------------------------
// mouse_packet_event_decoder: wheel-and-five-button mouse packet decoder
// Turns each packet into move, wheel-click and button press/release events.
// ----------------------------------------------------------------------------
// A packet is taken when the block is idle. In states S_CALC_X and S_CALC_Y
// one shared add-and-clamp unit updates first the x and then the y pointer
// position; the events of the packet then leave one per cycle through the
// output register while the output side does not stall, move first, then one
// per wheel step, then each changed button from 0 to 4, with last set on the
// final one. A packet carries at most fourteen events. The last event may
// still wait in the output register while the next packet is taken.
// Display size writes are taken at any time through the plain write port.
`default_nettype none

module mouse_packet_event_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mpd_pkt_if.sink                        i_pkt,
    mpd_evt_if.source                      o_evt,
    input  logic                           i_cfg_we,
    input  logic [mpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mpd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mpd_pkg::*;

    // Control and kept state
    t_state                r_state, n_state;
    logic [POS_W-1:0]      r_width, n_width;
    logic [POS_W-1:0]      r_height, n_height;
    logic [POS_W-1:0]      r_pos_x, n_pos_x;
    logic [POS_W-1:0]      r_pos_y, n_pos_y;
    logic [NBUTTONS-1:0]   r_btn, n_btn;
    logic [NBUTTONS-1:0]   r_change, n_change;
    logic                  r_move, n_move;
    logic [3:0]            r_wheel_cnt, n_wheel_cnt;
    logic                  r_wheel_up, n_wheel_up;
    logic                  r_out_valid, n_out_valid;

    // Packet payload held for the whole sequence
    logic signed [DELTA_W-1:0] r_dx, r_dy;

    // Output register payload
    t_event_kind           r_kind;
    logic [2:0]            r_index;
    logic [POS_W-1:0]      r_out_x, r_out_y;
    logic signed [9:0]     r_out_dx;
    logic signed [8:0]     r_out_dy;
    logic                  r_last;

    // Packet decode
    logic                  pkt_accept;
    logic signed [DELTA_W-1:0] pkt_dx, pkt_dy;
    logic [3:0]            pkt_nib;
    logic [3:0]            pkt_wheel_mag;
    logic [NBUTTONS-1:0]   pkt_levels;

    // Shared add-and-clamp unit
    logic                  u_axis_y;
    logic [POS_W-1:0]      u_pos;
    logic [POS_W-1:0]      u_size;
    logic [9:0]            u_delta;
    logic [17:0]           u_sum;
    logic [POS_W-1:0]      u_res;

    // Event selection
    logic                  load;
    t_event_kind           e_kind;
    logic [2:0]            e_index;
    logic                  e_last;
    logic [2:0]            e_btn_sel;
    logic [NBUTTONS-1:0]   e_change_next;

    assign i_pkt.ready = (r_state == S_IDLE);
    assign pkt_accept  = i_pkt.valid && i_pkt.ready;

    // Rebuild 9-bit movements and wheel magnitude
    assign pkt_dx        = {i_pkt.status_byte[4], i_pkt.x_byte};
    assign pkt_dy        = {i_pkt.status_byte[5], i_pkt.y_byte};
    assign pkt_nib       = i_pkt.extra_byte[3:0];
    assign pkt_wheel_mag = pkt_nib[3] ? 4'(5'd16 - {1'b0, pkt_nib}) : pkt_nib;
    assign pkt_levels    = {i_pkt.extra_byte[5:4], i_pkt.status_byte[2:0]};

    // Add the axis delta and clamp to the display size
    always_comb begin
        u_axis_y = (r_state == S_CALC_Y);
        u_pos    = u_axis_y ? r_pos_y : r_pos_x;
        u_size   = u_axis_y ? r_height : r_width;
        u_delta  = u_axis_y ? 10'(-{r_dy[DELTA_W-1], r_dy}) : {r_dx[DELTA_W-1], r_dx};
        u_sum    = {2'b00, u_pos} + {{8{u_delta[9]}}, u_delta};
        if (u_sum[17]) begin
            u_res = '0;
        end else if (u_size == '0) begin
            u_res = '0;
        end else if (u_sum[16:0] >= {1'b0, u_size}) begin
            u_res = u_size - POS_W'(1);
        end else begin
            u_res = u_sum[POS_W-1:0];
        end
    end

    // Pick the next event: move, then wheel steps, then lowest changed button
    always_comb begin
        e_btn_sel = '0;
        for (int i = NBUTTONS - 1; i >= 0; i--) begin
            if (r_change[i]) begin
                e_btn_sel = 3'(i);
            end
        end
        e_change_next = r_change & (r_change - NBUTTONS'(1));
        if (r_move) begin
            e_kind  = EV_MOVE;
            e_index = 3'd0;
            e_last  = (r_wheel_cnt == '0) && (r_change == '0);
        end else if (r_wheel_cnt != '0) begin
            e_kind  = r_wheel_up ? EV_WHEEL_UP : EV_WHEEL_DOWN;
            e_index = r_wheel_up ? BTN_WHEEL_UP : BTN_WHEEL_DOWN;
            e_last  = (r_wheel_cnt == 4'd1) && (r_change == '0);
        end else begin
            e_kind  = r_btn[e_btn_sel] ? EV_PRESS : EV_RELEASE;
            e_index = e_btn_sel;
            e_last  = (e_change_next == '0);
        end
    end

    assign load = (r_state == S_EMIT) && (!r_out_valid || o_evt.ready);

    // Sequencer: next state and state updates
    always_comb begin
        n_state     = r_state;
        n_width     = r_width;
        n_height    = r_height;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_btn       = r_btn;
        n_change    = r_change;
        n_move      = r_move;
        n_wheel_cnt = r_wheel_cnt;
        n_wheel_up  = r_wheel_up;
        n_out_valid = r_out_valid;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DISPLAY_WIDTH:  n_width  = i_cfg_data;
                CFG_DISPLAY_HEIGHT: n_height = i_cfg_data;
                default: ;
            endcase
        end

        if (o_evt.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (pkt_accept) begin
                    n_move      = (pkt_dx != '0) || (pkt_dy != '0);
                    n_wheel_cnt = pkt_wheel_mag;
                    n_wheel_up  = pkt_nib[3];
                    n_change    = pkt_levels ^ r_btn;
                    n_btn       = pkt_levels;
                    n_state     = S_CALC_X;
                end
            end
            S_CALC_X: begin
                if (r_move) begin
                    n_pos_x = u_res;
                end
                n_state = S_CALC_Y;
            end
            S_CALC_Y: begin
                if (r_move) begin
                    n_pos_y = u_res;
                end
                if (r_move || (r_wheel_cnt != '0) || (r_change != '0)) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (load) begin
                    n_out_valid = 1'b1;
                    if (r_move) begin
                        n_move = 1'b0;
                    end else if (r_wheel_cnt != '0) begin
                        n_wheel_cnt = r_wheel_cnt - 4'd1;
                    end else begin
                        n_change = e_change_next;
                    end
                    if (e_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_width     <= RST_DISPLAY_WIDTH;
            r_height    <= RST_DISPLAY_HEIGHT;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_btn       <= '0;
            r_change    <= '0;
            r_move      <= 1'b0;
            r_wheel_cnt <= '0;
            r_wheel_up  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_width     <= n_width;
            r_height    <= n_height;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_btn       <= n_btn;
            r_change    <= n_change;
            r_move      <= n_move;
            r_wheel_cnt <= n_wheel_cnt;
            r_wheel_up  <= n_wheel_up;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture packet movement and load the output register
    always_ff @(posedge i_clk) begin
        if (pkt_accept) begin
            r_dx <= pkt_dx;
            r_dy <= pkt_dy;
        end
        if (load) begin
            r_kind   <= e_kind;
            r_index  <= e_index;
            r_out_x  <= r_pos_x;
            r_out_y  <= r_pos_y;
            r_out_dx <= 10'(-{r_dx[DELTA_W-1], r_dx});
            r_out_dy <= r_dy;
            r_last   <= e_last;
        end
    end

    assign o_evt.valid        = r_out_valid;
    assign o_evt.event_kind   = r_kind;
    assign o_evt.button_index = r_index;
    assign o_evt.pointer_x    = r_out_x;
    assign o_evt.pointer_y    = r_out_y;
    assign o_evt.scroll_dx    = r_out_dx;
    assign o_evt.scroll_dy    = r_out_dy;
    assign o_evt.last         = r_last;

endmodule

`default_nettype wire

/* src/mpd_checker.sv */
// ----------------------------------------------------------------------------
// mpd_checker: port-level assertions for the mouse packet event decoder
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mpd_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [2:0]        i_kind,
    input  logic [2:0]        i_index,
    input  logic [15:0]       i_ptr_x,
    input  logic [15:0]       i_ptr_y,
    input  logic signed [9:0] i_sdx,
    input  logic signed [8:0] i_sdy,
    input  logic              i_last
);
    import mpd_pkg::*;

    // Hold a stalled event unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable({i_kind, i_index, i_ptr_x, i_ptr_y, i_sdx, i_sdy, i_last}))
        else $error("stalled output event changed");

    // Button index matches the event kind
    a_kind_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_kind == EV_MOVE && i_index == 3'd0)
         || (i_kind == EV_WHEEL_DOWN && i_index == BTN_WHEEL_DOWN)
         || (i_kind == EV_WHEEL_UP && i_index == BTN_WHEEL_UP)
         || ((i_kind == EV_PRESS || i_kind == EV_RELEASE) && i_index < 3'd5))
        else $error("button index does not fit event kind");

    // Go busy after taking a packet
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready right after a packet transaction");

    // Take no packet while one is still being emitted
    a_no_accept_mid_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> !i_in_ready)
        else $error("packet taken before previous packet finished");

endmodule

bind mouse_packet_event_decoder mpd_checker u_mpd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pkt.valid),
    .i_in_ready  (i_pkt.ready),
    .i_out_valid (o_evt.valid),
    .i_out_ready (o_evt.ready),
    .i_kind      (o_evt.event_kind),
    .i_index     (o_evt.button_index),
    .i_ptr_x     (o_evt.pointer_x),
    .i_ptr_y     (o_evt.pointer_y),
    .i_sdx       (o_evt.scroll_dx),
    .i_sdy       (o_evt.scroll_dy),
    .i_last      (o_evt.last)
);

`default_nettype wire
